// File: rtl/core/temporal_iir_bandpass_macros.svh
// Assertion macros shared by the temporal bandpass RTL.
// Clocked on i_clk and disabled while i_rst_n is low; no other dependencies.
`ifndef TEMPORAL_IIR_BANDPASS_MACROS_SVH
`define TEMPORAL_IIR_BANDPASS_MACROS_SVH

// Condition implies consequence in the same cycle.
`define TIB_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define TIB_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/tib_pkg.sv
// Package for the temporal bandpass filter: field widths, register codes
// and coefficient reset values. No dependencies.
package tib_pkg;

    localparam int INDEX_BITS     = 16;
    localparam int COEF_BITS      = 16;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COEF_HIGH = 1'b0,
        CFG_COEF_LOW  = 1'b1
    } t_cfg_reg;

    localparam logic [COEF_BITS-1:0] COEF_HIGH_RESET = 16'd32768;
    localparam logic [COEF_BITS-1:0] COEF_LOW_RESET  = 16'd4096;

endpackage

// File: rtl/core/tib_pix_if.sv
// Input channel of the temporal bandpass filter: one pyramid sample.
// Depends on tib_pkg.
interface tib_pix_if
    import tib_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic                          prime;
    logic [INDEX_BITS-1:0]         pixel_index;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, prime, pixel_index, sample, input ready);
    modport sink   (input valid, prime, pixel_index, sample, output ready);
endinterface

// File: rtl/core/tib_res_if.sv
// Result channel of the temporal bandpass filter: one bandpassed sample.
// Depends on tib_pkg.
interface tib_res_if
    import tib_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) ();
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_BITS:0] filtered;

    modport source (output valid, filtered, input ready);
    modport sink   (input valid, filtered, output ready);
endinterface

// File: rtl/core/tib_cfg_if.sv
// Register write channel of the temporal bandpass filter.
// Depends on tib_pkg.
interface tib_cfg_if
    import tib_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [COEF_BITS-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/temporal_iir_bandpass.sv
// Top level of the temporal bandpass filter: address stage, state memories,
// lowpass update and result register. Depends on tib_pkg, the tib_*_if
// interfaces, tib_lowpass and temporal_iir_bandpass_macros.svh.
//
// Usage: i_pix carries one pyramid sample per transfer (prime, pixel_index,
// sample); o_res returns exactly one filtered value per input, in order.
// i_cfg writes coef_high (index 0) or coef_low (index 1); it is always ready
// and is meant to be used while the block holds no item.
// Each address keeps a fast and a slow lowpass value in two memories of
// PIXELS words. An address that was never primed reads an undefined value.
// Stages: address stage, then memory read with update, then the result
// register. Throughput: one item per cycle while o_res is not stalled,
// also for back-to-back items at the same address, since the last write is
// forwarded around the registered memory read port.
// Reset clears the pipeline valid flags and restores the coefficient
// defaults; the memories are not cleared. When the receiver stalls, the
// result register holds, the two stages behind it fill, and i_pix.ready
// drops only when all three are occupied.
`include "temporal_iir_bandpass_macros.svh"

module temporal_iir_bandpass
    import tib_pkg::*;
#(
    parameter int PIXELS      = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tib_pix_if.sink   i_pix,
    tib_res_if.source o_res,
    tib_cfg_if.sink   i_cfg
);
    localparam int ADDR_W      = $clog2(PIXELS);
    localparam int EXT_W       = (ADDR_W > INDEX_BITS) ? ADDR_W : INDEX_BITS;
    localparam bit REDUCE      = (PIXELS < (1 << INDEX_BITS));
    localparam int RECIP_BITS  = INDEX_BITS + 1;
    localparam int RECIP_SHIFT = INDEX_BITS + ADDR_W;
    localparam int PROD_W      = INDEX_BITS + RECIP_BITS;
    localparam longint unsigned RECIP_VAL =
        REDUCE ? (((64'd1 << RECIP_SHIFT) + PIXELS - 1) / PIXELS) : 64'd0;
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);

    // Configuration registers.
    logic [COEF_BITS-1:0] r_coef_high;
    logic [COEF_BITS-1:0] r_coef_low;

    // Address stage.
    logic                          r_p_valid;
    logic                          r_p_prime;
    logic [INDEX_BITS-1:0]         r_p_index;
    logic [INDEX_BITS-1:0]         r_p_quot;
    logic signed [SAMPLE_BITS-1:0] r_p_sample;

    // Update stage, with the registered memory read data.
    logic                          r_s1_valid;
    logic                          r_s1_prime;
    logic [ADDR_W-1:0]             r_s1_addr;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic signed [SAMPLE_BITS-1:0] r_rd_fast;
    logic signed [SAMPLE_BITS-1:0] r_rd_slow;

    // Last write, forwarded to a read that missed it.
    logic                          r_wr_valid;
    logic [ADDR_W-1:0]             r_wr_addr;
    logic signed [SAMPLE_BITS-1:0] r_wr_fast;
    logic signed [SAMPLE_BITS-1:0] r_wr_slow;

    // Result register.
    logic                        r_out_valid;
    logic signed [SAMPLE_BITS:0] r_out_filtered;

    logic signed [SAMPLE_BITS-1:0] m_fast [PIXELS];
    logic signed [SAMPLE_BITS-1:0] m_slow [PIXELS];

    logic                          s1_adv;
    logic                          s1_free;
    logic                          p_adv;
    logic                          p_free;
    logic                          pix_xfer;
    logic [PROD_W-1:0]             quot_prod;
    logic [INDEX_BITS-1:0]         n_quot;
    logic [INDEX_BITS-1:0]         quot_mul;
    logic [INDEX_BITS-1:0]         rem;
    logic [EXT_W-1:0]              rem_ext;
    logic [ADDR_W-1:0]             p_addr;
    logic                          fwd_hit;
    logic signed [SAMPLE_BITS-1:0] cur_fast;
    logic signed [SAMPLE_BITS-1:0] cur_slow;
    logic signed [SAMPLE_BITS-1:0] n_fast;
    logic signed [SAMPLE_BITS-1:0] n_slow;
    logic signed [SAMPLE_BITS:0]   n_filtered;

    // Handshake chain across the three registers.
    always_comb begin
        s1_adv   = r_s1_valid && (!r_out_valid || o_res.ready);
        s1_free  = !r_s1_valid || s1_adv;
        p_adv    = r_p_valid && s1_free;
        p_free   = !r_p_valid || p_adv;
        pix_xfer = i_pix.valid && p_free;
    end

    assign i_pix.ready    = p_free;
    assign o_res.valid    = r_out_valid;
    assign o_res.filtered = r_out_filtered;
    assign i_cfg.ready    = 1'b1;

    // Index modulo PIXELS: reciprocal multiply, then one compare and subtract.
    always_comb begin
        quot_prod = PROD_W'(i_pix.pixel_index) * PROD_W'(RECIP);
        n_quot    = INDEX_BITS'(quot_prod >> RECIP_SHIFT);
        quot_mul  = INDEX_BITS'(32'(r_p_quot) * 32'(PIXELS));
        rem       = r_p_index - quot_mul;
        if (REDUCE && (32'(rem) >= 32'(PIXELS))) begin
            rem = rem - INDEX_BITS'(PIXELS);
        end
        rem_ext = EXT_W'(rem);
        p_addr  = rem_ext[ADDR_W-1:0];
    end

    always_comb begin
        fwd_hit  = r_wr_valid && (r_wr_addr == r_s1_addr);
        cur_fast = fwd_hit ? r_wr_fast : r_rd_fast;
        cur_slow = fwd_hit ? r_wr_slow : r_rd_slow;
    end

    tib_lowpass #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fast (
        .i_prime  (r_s1_prime),
        .i_lp     (cur_fast),
        .i_sample (r_s1_sample),
        .i_coef   (r_coef_high),
        .o_lp     (n_fast)
    );

    tib_lowpass #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_slow (
        .i_prime  (r_s1_prime),
        .i_lp     (cur_slow),
        .i_sample (r_s1_sample),
        .i_coef   (r_coef_low),
        .o_lp     (n_slow)
    );

    // Both lowpass values equal the sample on a primed item, so this is zero.
    assign n_filtered = (SAMPLE_BITS+1)'(n_fast) - (SAMPLE_BITS+1)'(n_slow);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_high <= COEF_HIGH_RESET;
            r_coef_low  <= COEF_LOW_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_COEF_HIGH: r_coef_high <= i_cfg.data;
                CFG_COEF_LOW:  r_coef_low  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (p_free) begin
                r_p_valid <= i_pix.valid;
            end
            if (s1_free) begin
                r_s1_valid <= p_adv;
            end
            if (s1_adv) begin
                r_wr_valid  <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (pix_xfer) begin
            r_p_prime  <= i_pix.prime;
            r_p_index  <= i_pix.pixel_index;
            r_p_quot   <= n_quot;
            r_p_sample <= i_pix.sample;
        end
        if (p_adv) begin
            r_s1_prime  <= r_p_prime;
            r_s1_addr   <= p_addr;
            r_s1_sample <= r_p_sample;
        end
        if (s1_adv) begin
            r_wr_addr      <= r_s1_addr;
            r_wr_fast      <= n_fast;
            r_wr_slow      <= n_slow;
            r_out_filtered <= n_filtered;
        end
    end

    // State memories: one registered read and one write per cycle each.
    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_rd_fast <= m_fast[p_addr];
            r_rd_slow <= m_slow[p_addr];
        end
        if (s1_adv) begin
            m_fast[r_s1_addr] <= n_fast;
            m_slow[r_s1_addr] <= n_slow;
        end
    end

    `TIB_ASSERT_NEXT(a_s1_to_out, s1_adv, r_out_valid,
        "update stage advanced but no result is held")
    `TIB_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_adv, r_s1_valid,
        "stalled item lost from the update stage")
    `TIB_ASSERT_NEXT(a_p_to_s1, p_adv, r_s1_valid,
        "address stage advanced but update stage is empty")
    `TIB_ASSERT_NEXT(a_fwd_addr, s1_adv,
        r_wr_valid && (r_wr_addr == $past(r_s1_addr)),
        "forwarding register does not hold the last written address")
    `TIB_ASSERT_NEXT(a_prime_zero, s1_adv && r_s1_prime, r_out_filtered == '0,
        "primed item gave a nonzero result")
    `TIB_ASSERT_NOW(a_ready_free, !i_pix.ready, r_p_valid && r_s1_valid && r_out_valid,
        "input stalled while a pipeline register is free")
endmodule

// File: rtl/core/tib_lowpass.sv
// One first-order lowpass update in Q0.16: lp + floor(coef * (x - lp) / 2^16),
// or a load of the sample on a primed item. Depends on tib_pkg.
module tib_lowpass
    import tib_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_prime,
    input  logic signed [SAMPLE_BITS-1:0] i_lp,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [COEF_BITS-1:0]          i_coef,
    output logic signed [SAMPLE_BITS-1:0] o_lp
);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS + 2;

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [COEF_BITS:0]     coef_s;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      step;
    logic signed [SAMPLE_BITS:0]   sum;

    always_comb begin
        diff   = (SAMPLE_BITS+1)'(i_sample) - (SAMPLE_BITS+1)'(i_lp);
        coef_s = signed'({1'b0, i_coef});
        prod   = PROD_W'(coef_s) * PROD_W'(diff);
        // Arithmetic shift rounds toward minus infinity.
        step   = prod >>> COEF_BITS;
        // The new value lies between the old value and the sample, so it fits.
        sum    = (SAMPLE_BITS+1)'(i_lp) + step[SAMPLE_BITS:0];
        o_lp   = i_prime ? i_sample : sum[SAMPLE_BITS-1:0];
    end
endmodule
